// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

// File: rtl/rtphp_pkg.sv
// ---------------------------------------------------------------------------
// RTP header parser package
// Word types, header constants and status codes shared by the parser.
// ---------------------------------------------------------------------------
package rtphp_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 65536;
  localparam int unsigned POS_W            = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned OFF_W            = POS_W + 2;

  localparam int unsigned HDR_BYTES     = 12;
  localparam int unsigned EXT_HDR_BYTES = 4;
  localparam logic [1:0]  RTP_VERSION   = 2'd2;
  localparam logic [7:0]  PT_NONE       = 8'd128;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_VERSION   = 3'd2,
    ST_WRONG_PT  = 3'd3,
    ST_TRUNC_EXT = 3'd4,
    ST_NO_PAY    = 3'd5,
    ST_PADDING   = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        marker_bit;
    logic [6:0]  payload_type;
    logic [15:0] sequence_number;
    logic [31:0] rtp_timestamp;
    logic [31:0] sync_source;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic [31:0] packet_count;
    logic [47:0] byte_count;
  } out_word_t;

  // header state of one packet as seen after its last byte
  typedef struct packed {
    logic [POS_W-1:0] n_bytes;
    logic [7:0]       hdr0;
    logic [7:0]       hdr1;
    logic [15:0]      seq;
    logic [31:0]      ts;
    logic [31:0]      ssrc;
    logic [15:0]      ext_len;
    logic [7:0]       kept;
  } hdr_snap_t;

  typedef struct packed {
    status_e     status;
    logic        marker_bit;
    logic [6:0]  payload_type;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [31:0] ssrc;
    logic [15:0] offset;
    logic [15:0] length;
  } chk_word_t;

endpackage

// File: rtl/rtp_header_parser.sv
// ---------------------------------------------------------------------------
// RTP header parser
// Parses RFC 3550 fixed headers from a byte stream and reports each packet.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: one packet byte per word (data_byte, last_byte), accepted
//   when in_valid_i is high and in_stall_o is low. One byte per cycle
//   is sustained unless stalled; bytes past 65536 in a packet are dropped.
//   Output channel: one word per packet, on its last byte, taken when
//   out_valid_o is high and out_stall_i is low. After the last byte is
//   accepted, the result passes the input register, header capture, check
//   and the result/counter register in that order.
//   Config channel: cfg_data_i sets the accepted payload type when
//   cfg_valid_i is high; cfg_ready_o is always high. Write only while idle.
//   Each stage has its own handshake: while the receiver stalls, the result
//   word holds and earlier stages keep filling, so non-last bytes keep
//   flowing; once check and capture both hold finished packets, the next
//   last byte stalls the input.
//   Reset drops any partial packet, clears the packet and byte counters and
//   sets the payload type to 128, which rejects every packet.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rtp_header_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rtphp_pkg::in_word_t   in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rtphp_pkg::out_word_t  out_word_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [7:0]            cfg_data_i
);

  logic                 in_valid_q;
  rtphp_pkg::in_word_t  in_word_q;
  logic                 cap_ready;
  logic                 snap_valid, snap_ready;
  rtphp_pkg::hdr_snap_t snap;
  logic                 chk_valid, chk_ready, chk_fire;
  rtphp_pkg::chk_word_t chk;
  logic [7:0]           exp_pt_q;
  logic [31:0]          pkt_cnt_q, pkt_cnt_d;
  logic [47:0]          byte_cnt_q, byte_cnt_d;
  logic                 out_valid_q;
  rtphp_pkg::out_word_t out_word_q;
  logic                 chk_ok;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_pt_q <= rtphp_pkg::PT_NONE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      exp_pt_q <= cfg_data_i;
    end
  end

  // input register
  assign in_stall_o = in_valid_q && !cap_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= in_word_i;
    end
  end

  rtphp_capture u_capture (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_q),
    .in_ready_o   (cap_ready),
    .in_word_i    (in_word_q),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  rtphp_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .exp_pt_i     (exp_pt_q),
    .chk_valid_o  (chk_valid),
    .chk_ready_i  (chk_ready),
    .chk_o        (chk)
  );

  // counters and result register
  assign chk_ready = !out_valid_q || !out_stall_i;
  assign chk_fire  = chk_valid && chk_ready;
  assign chk_ok    = chk.status == rtphp_pkg::ST_OK;
  assign pkt_cnt_d  = chk_ok ? pkt_cnt_q + 32'd1 : pkt_cnt_q;
  assign byte_cnt_d = chk_ok ? byte_cnt_q + 48'(chk.length) : byte_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pkt_cnt_q   <= '0;
      byte_cnt_q  <= '0;
    end else begin
      if (chk_ready) begin
        out_valid_q <= chk_valid;
      end
      if (chk_fire) begin
        pkt_cnt_q  <= pkt_cnt_d;
        byte_cnt_q <= byte_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (chk_fire) begin
      out_word_q <= '{status: chk.status, marker_bit: chk.marker_bit,
                      payload_type: chk.payload_type, sequence_number: chk.seq,
                      rtp_timestamp: chk.ts, sync_source: chk.ssrc,
                      payload_offset: chk.offset, payload_length: chk.length,
                      packet_count: pkt_cnt_d, byte_count: byte_cnt_d};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `ASSERT_PROP(a_reject_zero, clk_i, rst_ni, out_valid_o && out_word_o.status != rtphp_pkg::ST_OK |-> out_word_o.payload_offset == '0 && out_word_o.payload_length == '0, "rejected packet carries offset or length")
  `ASSERT_PROP(a_ok_offset, clk_i, rst_ni, out_valid_o && out_word_o.status == rtphp_pkg::ST_OK |-> out_word_o.payload_offset[1:0] == 2'b00 && out_word_o.payload_offset >= 16'(rtphp_pkg::HDR_BYTES), "bad payload offset on accepted packet")
  `ASSERT_PROP(a_count_on_ok, clk_i, rst_ni, !$stable(pkt_cnt_q) |-> $past(chk_fire && chk_ok), "packet counter moved without accepted packet")
  `ASSERT_NEVER(a_no_drop, clk_i, rst_ni, out_valid_q && out_stall_i && chk_fire, "check word moved into a stalled result register")

endmodule

// File: rtl/rtphp_capture.sv
// ---------------------------------------------------------------------------
// RTP header capture
// Walks the packet bytes, collects header fields, snapshots on the last byte.
// ---------------------------------------------------------------------------
module rtphp_capture (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rtphp_pkg::in_word_t  in_word_i,
  output logic                 snap_valid_o,
  input  logic                 snap_ready_i,
  output rtphp_pkg::hdr_snap_t snap_o
);

  logic [rtphp_pkg::POS_W-1:0] pos_q, pos_d;
  logic [7:0]  hdr0_q, hdr0_d, hdr1_q, hdr1_d, kept_q, kept_d;
  logic [15:0] seq_q, seq_d, ext_q, ext_d;
  logic [31:0] ts_q, ts_d, ssrc_q, ssrc_d;
  logic [rtphp_pkg::POS_W-1:0] ext_pos;
  logic        take, go;
  logic        snap_valid_q;
  rtphp_pkg::hdr_snap_t snap_q;

  assign in_ready_o = !in_word_i.last_byte || !snap_valid_q || snap_ready_i;
  assign go         = in_valid_i && in_ready_o;
  assign take       = pos_q < rtphp_pkg::POS_W'(rtphp_pkg::MAX_PACKET_BYTES);
  assign ext_pos    = rtphp_pkg::POS_W'(rtphp_pkg::HDR_BYTES)
                    + rtphp_pkg::POS_W'({hdr0_q[3:0], 2'b00}) + 2;

  always_comb begin
    pos_d  = pos_q;
    hdr0_d = hdr0_q;
    hdr1_d = hdr1_q;
    seq_d  = seq_q;
    ts_d   = ts_q;
    ssrc_d = ssrc_q;
    ext_d  = ext_q;
    kept_d = kept_q;
    if (take) begin
      priority if (pos_q == 0) begin
        hdr0_d = in_word_i.data_byte;
      end else if (pos_q == 1) begin
        hdr1_d = in_word_i.data_byte;
      end else if (pos_q < 4) begin
        seq_d = {seq_q[7:0], in_word_i.data_byte};
      end else if (pos_q < 8) begin
        ts_d = {ts_q[23:0], in_word_i.data_byte};
      end else if (pos_q < rtphp_pkg::POS_W'(rtphp_pkg::HDR_BYTES)) begin
        ssrc_d = {ssrc_q[23:0], in_word_i.data_byte};
      end else if (pos_q == ext_pos || pos_q == ext_pos + 1) begin
        ext_d = {ext_q[7:0], in_word_i.data_byte};
      end
      kept_d = in_word_i.data_byte;
      pos_d  = pos_q + 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hdr0_q <= '0;
      hdr1_q <= '0;
      seq_q  <= '0;
      ts_q   <= '0;
      ssrc_q <= '0;
      ext_q  <= '0;
      kept_q <= '0;
    end else if (go) begin
      if (in_word_i.last_byte) begin
        pos_q  <= '0;
        hdr0_q <= '0;
        hdr1_q <= '0;
        seq_q  <= '0;
        ts_q   <= '0;
        ssrc_q <= '0;
        ext_q  <= '0;
        kept_q <= '0;
      end else begin
        pos_q  <= pos_d;
        hdr0_q <= hdr0_d;
        hdr1_q <= hdr1_d;
        seq_q  <= seq_d;
        ts_q   <= ts_d;
        ssrc_q <= ssrc_d;
        ext_q  <= ext_d;
        kept_q <= kept_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (go && in_word_i.last_byte) begin
      snap_valid_q <= 1'b1;
    end else if (snap_ready_i) begin
      snap_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && in_word_i.last_byte) begin
      snap_q <= '{n_bytes: pos_d, hdr0: hdr0_d, hdr1: hdr1_d, seq: seq_d, ts: ts_d,
                  ssrc: ssrc_d, ext_len: ext_d, kept: kept_d};
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

// File: rtl/rtphp_check.sv
// ---------------------------------------------------------------------------
// RTP header check
// Judges one captured header and works out payload offset and length.
// ---------------------------------------------------------------------------
module rtphp_check (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 snap_valid_i,
  output logic                 snap_ready_o,
  input  rtphp_pkg::hdr_snap_t snap_i,
  input  logic [7:0]           exp_pt_i,
  output logic                 chk_valid_o,
  input  logic                 chk_ready_i,
  output rtphp_pkg::chk_word_t chk_o
);

  logic [rtphp_pkg::OFF_W-1:0] n_ext, off_base, off;
  logic [rtphp_pkg::POS_W-1:0] plen_full, plen;
  logic                        ext_on, pad_on;
  rtphp_pkg::status_e          st;
  logic                        chk_valid_q;
  rtphp_pkg::chk_word_t        chk_q;

  assign n_ext    = rtphp_pkg::OFF_W'(snap_i.n_bytes);
  assign off_base = rtphp_pkg::OFF_W'(rtphp_pkg::HDR_BYTES)
                  + rtphp_pkg::OFF_W'({snap_i.hdr0[3:0], 2'b00});
  assign ext_on   = snap_i.hdr0[4];
  assign pad_on   = snap_i.hdr0[5];
  assign off      = ext_on ? off_base + rtphp_pkg::OFF_W'(rtphp_pkg::EXT_HDR_BYTES)
                             + rtphp_pkg::OFF_W'({snap_i.ext_len, 2'b00})
                           : off_base;
  assign plen_full = snap_i.n_bytes - off[rtphp_pkg::POS_W-1:0];
  assign plen      = pad_on ? plen_full - rtphp_pkg::POS_W'(snap_i.kept) : plen_full;

  always_comb begin
    priority if (snap_i.n_bytes < rtphp_pkg::POS_W'(rtphp_pkg::HDR_BYTES)) begin
      st = rtphp_pkg::ST_SHORT;
    end else if (snap_i.hdr0[7:6] != rtphp_pkg::RTP_VERSION) begin
      st = rtphp_pkg::ST_VERSION;
    end else if ({1'b0, snap_i.hdr1[6:0]} != exp_pt_i) begin
      st = rtphp_pkg::ST_WRONG_PT;
    end else if (ext_on &&
                 n_ext < off_base + rtphp_pkg::OFF_W'(rtphp_pkg::EXT_HDR_BYTES)) begin
      st = rtphp_pkg::ST_TRUNC_EXT;
    end else if (off >= n_ext) begin
      st = rtphp_pkg::ST_NO_PAY;
    end else if (pad_on && rtphp_pkg::POS_W'(snap_i.kept) > plen_full) begin
      st = rtphp_pkg::ST_PADDING;
    end else begin
      st = rtphp_pkg::ST_OK;
    end
  end

  assign snap_ready_o = !chk_valid_q || chk_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_valid_q <= 1'b0;
    end else if (snap_ready_o) begin
      chk_valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_ready_o && snap_valid_i) begin
      chk_q.status       <= st;
      chk_q.marker_bit   <= snap_i.hdr1[7];
      chk_q.payload_type <= snap_i.hdr1[6:0];
      chk_q.seq          <= snap_i.seq;
      chk_q.ts           <= snap_i.ts;
      chk_q.ssrc         <= snap_i.ssrc;
      chk_q.offset       <= (st == rtphp_pkg::ST_OK) ? off[15:0] : '0;
      chk_q.length       <= (st == rtphp_pkg::ST_OK) ? plen[15:0] : '0;
    end
  end

  assign chk_valid_o = chk_valid_q;
  assign chk_o       = chk_q;

endmodule
